>>> sv/ltsvc_pkg.sv
// Shared constants and types for the LRU tag store with victim cache.
package ltsvc_pkg;
   localparam int NUM_SETS_DEF = 64;
   localparam int ASSOC_DEF = 4;
   localparam int VICTIM_ENTRIES_DEF = 8;
   localparam int BLOCK_BYTES_DEF = 64;
   localparam int ADDR_BITS_DEF = 32;

   localparam logic [1:0] CMD_ACCESS = 2'd0;
   localparam logic [1:0] CMD_PROBE = 2'd1;
   localparam logic [1:0] CMD_FILL = 2'd2;
   localparam logic [1:0] CMD_INVAL = 2'd3;

   localparam logic [1:0] PLACE_NONE = 2'd0;
   localparam logic [1:0] PLACE_MAIN = 2'd1;
   localparam logic [1:0] PLACE_VICTIM = 2'd2;

   typedef struct packed {
      logic load;
      logic update;
   } ctrl_type;

   typedef struct packed {
      logic clearing;
   } status_type;
endpackage

>>> sv/ltsvc_ctrl.sv
// Controller sequencing reset clearing, lookup and write-back of one transaction.
module ltsvc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ltsvc_pkg::status_type status,
   output ltsvc_pkg::ctrl_type  ctrl
);
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_UPD = 2'd2;
   localparam logic [1:0] S_RSP = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = !(state_ff == S_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = state_ff == S_RSP;
   assign ctrl.load = accept;
   assign ctrl.update = state_ff == S_UPD;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (!status.clearing) state_in = S_IDLE;
         S_IDLE:  if (accept) state_in = S_UPD;
         S_UPD:   state_in = S_RSP;
         S_RSP:   if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end
endmodule

>>> sv/ltsvc_datapath.sv
// Datapath holding the set memory, the victim entries and the lookup and update logic.
module ltsvc_datapath #(
   parameter int NUM_SETS = ltsvc_pkg::NUM_SETS_DEF,
   parameter int ASSOC = ltsvc_pkg::ASSOC_DEF,
   parameter int VICTIM_ENTRIES = ltsvc_pkg::VICTIM_ENTRIES_DEF,
   parameter int BLOCK_BYTES = ltsvc_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS = ltsvc_pkg::ADDR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ltsvc_pkg::ctrl_type   ctrl,
   output ltsvc_pkg::status_type status,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_addr,
   output logic                  rsp_hit,
   output logic [1:0]            rsp_hit_place,
   output logic [2:0]            rsp_hit_slot,
   output logic                  rsp_evict_valid,
   output logic [31:0]           rsp_evict_addr
);
   localparam int OFFB = $clog2(BLOCK_BYTES);
   localparam int SETB = $clog2(NUM_SETS);
   localparam int SW = (SETB > 0) ? SETB : 1;
   localparam int TAGW = (ADDR_BITS - OFFB - SETB > 0) ? ADDR_BITS - OFFB - SETB : 1;
   localparam int RW = (ASSOC > 1) ? $clog2(ASSOC) : 1;
   localparam int VW = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;

   typedef struct packed {
      logic [TAGW-1:0] tag;
      logic            valid;
      logic [RW-1:0]   rank;
   } way_type;
   typedef way_type [ASSOC-1:0] row_type;

   row_type         mem [NUM_SETS];
   row_type         row_ff;
   logic [SW-1:0]   clr_ff;
   logic            clearing_ff;
   logic [1:0]      cmd_ff;
   logic [SW-1:0]   set_ff;
   logic [TAGW-1:0] tag_ff;

   logic [TAGW-1:0] vtag_ff [VICTIM_ENTRIES];
   logic [SW-1:0]   vset_ff [VICTIM_ENTRIES];
   logic            vval_ff [VICTIM_ENTRIES];
   logic [VW-1:0]   vrank_ff [VICTIM_ENTRIES];

   logic [63:0]     addr_ext;
   logic [SW-1:0]   req_set;
   logic [TAGW-1:0] req_tag;
   row_type         reset_row, row_in;
   logic [1:0]      place;
   logic [2:0]      slot;
   logic [RW-1:0]   mway, lway;
   logic [VW-1:0]   vslot, lvic;
   logic            ev_v;
   logic [31:0]     ev_a;
   logic [63:0]     ev_wide;
   logic            vwe;
   logic [VW-1:0]   vidx;
   logic [TAGW-1:0] vtag_in;
   logic            vval_in;
   logic            vmru;

   assign addr_ext = {32'd0, req_addr} & ((ADDR_BITS >= 64) ? {64{1'b1}} :
                     ((64'd1 << ADDR_BITS) - 64'd1));
   assign req_set = (SETB > 0) ? SW'(addr_ext >> OFFB) : '0;
   assign req_tag = TAGW'(addr_ext >> (OFFB + SETB));
   assign status.clearing = clearing_ff;

   always_comb begin
      for (int w = 0; w < ASSOC; w++) begin
         reset_row[w].tag = '0;
         reset_row[w].valid = 1'b0;
         reset_row[w].rank = RW'(w);
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) mem[clr_ff] <= reset_row;
      else if (ctrl.update) mem[set_ff] <= row_in;
      if (ctrl.load) row_ff <= mem[req_set];
      if (ctrl.load) begin
         cmd_ff <= req_cmd;
         set_ff <= req_set;
         tag_ff <= req_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clearing_ff <= 1'b1;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (int'(clr_ff) == NUM_SETS - 1) clearing_ff <= 1'b0;
      end
   end

   always_comb begin
      place = ltsvc_pkg::PLACE_NONE;
      mway = '0;
      vslot = '0;
      lway = '0;
      lvic = '0;
      for (int w = ASSOC - 1; w >= 0; w--)
         if (row_ff[w].valid && row_ff[w].tag == tag_ff) begin
            place = ltsvc_pkg::PLACE_MAIN;
            mway = RW'(w);
         end
      if (place == ltsvc_pkg::PLACE_NONE)
         for (int e = VICTIM_ENTRIES - 1; e >= 0; e--)
            if (vval_ff[e] && vtag_ff[e] == tag_ff && vset_ff[e] == set_ff) begin
               place = ltsvc_pkg::PLACE_VICTIM;
               vslot = VW'(e);
            end
      for (int w = ASSOC - 1; w >= 0; w--)
         if (int'(row_ff[w].rank) == ASSOC - 1) lway = RW'(w);
      for (int e = VICTIM_ENTRIES - 1; e >= 0; e--)
         if (int'(vrank_ff[e]) == VICTIM_ENTRIES - 1) lvic = VW'(e);
      slot = (place == ltsvc_pkg::PLACE_MAIN) ? 3'(mway) :
             (place == ltsvc_pkg::PLACE_VICTIM) ? 3'(vslot) : 3'd0;
   end

   always_comb begin
      row_in = row_ff;
      vwe = 1'b0;
      vidx = vslot;
      vtag_in = row_ff[lway].tag;
      vval_in = row_ff[lway].valid;
      vmru = 1'b0;
      ev_v = 1'b0;
      ev_wide = ({32'd0, vtag_ff[lvic]} << (OFFB + SETB)) |
                ({{(64-SW){1'b0}}, vset_ff[lvic]} << OFFB);
      ev_a = 32'(ev_wide);
      case (cmd_ff)
         ltsvc_pkg::CMD_ACCESS: begin
            if (place == ltsvc_pkg::PLACE_MAIN) begin
               for (int j = 0; j < ASSOC; j++)
                  if (row_ff[j].rank < row_ff[mway].rank)
                     row_in[j].rank = row_ff[j].rank + 1'b1;
               row_in[mway].rank = '0;
            end else if (place == ltsvc_pkg::PLACE_VICTIM) begin
               row_in[lway].tag = vtag_ff[vslot];
               row_in[lway].valid = vval_ff[vslot];
               for (int j = 0; j < ASSOC; j++)
                  if (row_ff[j].rank < row_ff[lway].rank)
                     row_in[j].rank = row_ff[j].rank + 1'b1;
               row_in[lway].rank = '0;
               vwe = 1'b1;
               vmru = 1'b1;
            end
         end
         ltsvc_pkg::CMD_FILL: begin
            if (place == ltsvc_pkg::PLACE_NONE) begin
               ev_v = vval_ff[lvic];
               vwe = 1'b1;
               vidx = lvic;
               vmru = 1'b1;
               row_in[lway].tag = tag_ff;
               row_in[lway].valid = 1'b1;
               for (int j = 0; j < ASSOC; j++)
                  if (row_ff[j].rank < row_ff[lway].rank)
                     row_in[j].rank = row_ff[j].rank + 1'b1;
               row_in[lway].rank = '0;
            end
         end
         ltsvc_pkg::CMD_INVAL: begin
            if (place == ltsvc_pkg::PLACE_MAIN) begin
               row_in[mway].valid = 1'b0;
               for (int j = 0; j < ASSOC; j++)
                  if (row_ff[j].rank > row_ff[mway].rank)
                     row_in[j].rank = row_ff[j].rank - 1'b1;
               row_in[mway].rank = RW'(ASSOC - 1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < VICTIM_ENTRIES; e++) begin
            vtag_ff[e] <= '0;
            vset_ff[e] <= '0;
            vval_ff[e] <= 1'b0;
            vrank_ff[e] <= VW'(e);
         end
      end else if (ctrl.update) begin
         if (cmd_ff == ltsvc_pkg::CMD_INVAL && place == ltsvc_pkg::PLACE_VICTIM)
            vval_ff[vslot] <= 1'b0;
         if (vwe) begin
            vtag_ff[vidx] <= vtag_in;
            vval_ff[vidx] <= vval_in;
            vset_ff[vidx] <= set_ff;
         end
         if (vmru)
            for (int e = 0; e < VICTIM_ENTRIES; e++)
               if (VW'(e) == vidx) vrank_ff[e] <= '0;
               else if (vrank_ff[e] < vrank_ff[vidx]) vrank_ff[e] <= vrank_ff[e] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         rsp_hit <= place != ltsvc_pkg::PLACE_NONE;
         rsp_hit_place <= place;
         rsp_hit_slot <= slot;
         rsp_evict_valid <= ev_v;
         rsp_evict_addr <= ev_v ? ev_a : 32'd0;
      end
   end
endmodule

>>> sv/lru_tag_store_with_victim_cache.sv
// Top level of the LRU tag store with victim cache.
// A transaction's set row is read on acceptance, then written back in the update state;
// the result is then offered and held while rsp_stall is high.
// A new transaction is accepted only after the result of the last one has been taken.
// The victim store order and the set memory are updated in the update state.
// Reset is synchronous; afterwards a clearing pass writes every set row,
// and the first transaction is accepted only after the pass ends.
module lru_tag_store_with_victim_cache #(
   parameter int NUM_SETS = ltsvc_pkg::NUM_SETS_DEF,
   parameter int ASSOC = ltsvc_pkg::ASSOC_DEF,
   parameter int VICTIM_ENTRIES = ltsvc_pkg::VICTIM_ENTRIES_DEF,
   parameter int BLOCK_BYTES = ltsvc_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS = ltsvc_pkg::ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [1:0]  rsp_hit_place,
   output logic [2:0]  rsp_hit_slot,
   output logic        rsp_evict_valid,
   output logic [31:0] rsp_evict_addr
);
   ltsvc_pkg::ctrl_type   ctrl;
   ltsvc_pkg::status_type status;

   ltsvc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .ctrl(ctrl)
   );

   ltsvc_datapath #(
      .NUM_SETS(NUM_SETS), .ASSOC(ASSOC), .VICTIM_ENTRIES(VICTIM_ENTRIES),
      .BLOCK_BYTES(BLOCK_BYTES), .ADDR_BITS(ADDR_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .status(status),
      .req_cmd(req_cmd), .req_addr(req_addr), .rsp_hit(rsp_hit),
      .rsp_hit_place(rsp_hit_place), .rsp_hit_slot(rsp_hit_slot),
      .rsp_evict_valid(rsp_evict_valid), .rsp_evict_addr(rsp_evict_addr)
   );
endmodule
